// ===== rtl/saz_pkg.sv =====
// shared types, constants and helper functions for the solar position core
package saz_pkg;

   // cordic depth and datapath widths
   localparam int STAGES = 28;
   localparam int CW     = 36;
   localparam int QW     = 33;
   localparam int SC_LAT = STAGES + 2;
   localparam int LAT    = 9 + 7 * SC_LAT;

   typedef logic signed [CW-1:0] cw_type;
   typedef logic signed [QW-1:0] qv_type;

   // one cordic cell's worth of state
   typedef struct packed {
      cw_type x;
      cw_type y;
      cw_type z;
      logic   flag;
   } cstate_type;

   // split partial products of a time term
   typedef struct packed {
      logic [63:0] lo;
      logic [63:0] hi;
   } pp_type;

   // csr register indexes
   localparam logic REG_LAT = 1'b0;
   localparam logic REG_LON = 1'b1;

   // angle constants in binary turns
   localparam logic [31:0] L0_T   = 32'(((64'd280460 << 32) + 64'd180000) / 64'd360000);
   localparam logic [31:0] G0_T   = 32'(((64'd357528 << 32) + 64'd180000) / 64'd360000);
   localparam logic [31:0] EC1_T  = 32'(((64'd1915 << 32) + 64'd180000) / 64'd360000);
   localparam logic [31:0] EC2_T  = 32'(((64'd20 << 32) + 64'd180000) / 64'd360000);
   localparam logic [31:0] EPS0_T = 32'(((64'd23439 << 32) + 64'd180000) / 64'd360000);

   // daily rates in turns * 2^48
   localparam logic [63:0] RATE_L   = ((64'd9856474 << 38) + 64'd1757812) / 64'd3515625;
   localparam logic [63:0] RATE_G   = ((64'd9856003 << 38) + 64'd1757812) / 64'd3515625;
   localparam logic [63:0] RATE_EPS = ((64'd1 << 40) + 64'd1757812) / 64'd3515625;
   localparam logic [31:0] GMST0_T  =
      32'(((64'd18697374558 << 20) + 64'd2929687) / 64'd5859375);
   localparam logic [63:0] GM_A     = 64'd6570982442;
   localparam logic [63:0] GM_D     = 64'd146484375;
   localparam logic [63:0] GM_FRAC  = ((((GM_A << 30) / GM_D) << 4)
      + (((((GM_A << 30) % GM_D) << 4) + GM_D / 64'd2) / GM_D));
   localparam logic [63:0] RATE_GMST = (64'd1 << 48) + GM_FRAC;

   // cordic and conversion constants
   localparam logic [63:0] INV_PI_Q33 = 64'd2734261102;
   localparam logic [31:0] PI_Q30     = 32'd3373259426;
   localparam cw_type      CORDIC_K   = 36'sd652032874;
   localparam cw_type      HALF_TURN  = 36'sh080000000;
   localparam cw_type      QTR_TURN   = 36'sh040000000;
   localparam cw_type      NQTR_TURN  = -36'sh040000000;

   // reciprocal of 45 for the degree to turn conversion
   localparam logic [63:0] MREC = (64'd1 << 44) / 64'd45;

   // restoring division, used only for building constants
   function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] b);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int j = 63; j >= 0; j--) begin
         r = {r[62:0], a[j]};
         if (r >= b) begin
            r    = r - b;
            q[j] = 1'b1;
         end
      end
      return q;
   endfunction

   // arctangent of 2^-i in turns from the integer series
   function automatic logic [31:0] atan_entry(int i);
      logic [63:0] acc;
      logic [63:0] term;
      logic [63:0] r;
      logic [63:0] prod;
      acc = '0;
      if (i == 0) begin
         return 32'h2000_0000;
      end
      for (int k = 1; i * k <= 62; k += 2) begin
         term = udiv64(64'd1 << (62 - i * k), 64'(k));
         if (((k >> 1) & 1) == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      r    = (acc + (64'd1 << 29)) >> 30;
      prod = r * INV_PI_Q33 + (64'd1 << 33);
      return 32'(prod >> 34);
   endfunction

   // q30 product with round half up
   function automatic qv_type mulq(qv_type a, qv_type b);
      logic signed [2*QW-1:0] p;
      p = a * b + (66'sd1 <<< 29);
      return p[QW+29:30];
   endfunction

   // partial products of day offset times a rate
   function automatic pp_type pprod(logic signed [32:0] n, logic [63:0] rate);
      logic signed [58:0] pl;
      logic signed [58:0] ph;
      pp_type r;
      pl   = n * $signed({1'b0, rate[24:0]});
      ph   = n * $signed({1'b0, rate[49:25]});
      r.lo = {{5{pl[58]}}, pl};
      r.hi = {{5{ph[58]}}, ph};
      return r;
   endfunction

   // recombine the partial products modulo 2^64
   function automatic logic [63:0] hsum(pp_type p);
      return p.lo + (p.hi << 25);
   endfunction

endpackage

// ===== rtl/saz_rot_cell.sv =====
// one rotation-mode cordic cell
module saz_rot_cell (
   input  logic                 clock,
   input  logic [5:0]           shift,
   input  logic [31:0]          atan,
   input  saz_pkg::cstate_type  c_in,
   output saz_pkg::cstate_type  c_out
);

   saz_pkg::cstate_type c_ff;
   saz_pkg::cstate_type c_in_nxt;
   saz_pkg::cw_type     xs;
   saz_pkg::cw_type     ys;
   saz_pkg::cw_type     av;

   // rotate toward zero residual angle
   always_comb begin
      xs       = c_in.x >>> shift;
      ys       = c_in.y >>> shift;
      av       = $signed({{(saz_pkg::CW-32){1'b0}}, atan});
      c_in_nxt = c_in;
      if (!c_in.z[saz_pkg::CW-1]) begin
         c_in_nxt.x = c_in.x - ys;
         c_in_nxt.y = c_in.y + xs;
         c_in_nxt.z = c_in.z - av;
      end else begin
         c_in_nxt.x = c_in.x + ys;
         c_in_nxt.y = c_in.y - xs;
         c_in_nxt.z = c_in.z + av;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in_nxt;
   end

   assign c_out = c_ff;

endmodule

// ===== rtl/saz_vec_cell.sv =====
// one vectoring-mode cordic cell
module saz_vec_cell (
   input  logic                 clock,
   input  logic [5:0]           shift,
   input  logic [31:0]          atan,
   input  saz_pkg::cstate_type  c_in,
   output saz_pkg::cstate_type  c_out
);

   saz_pkg::cstate_type c_ff;
   saz_pkg::cstate_type c_in_nxt;
   saz_pkg::cw_type     xs;
   saz_pkg::cw_type     ys;
   saz_pkg::cw_type     av;

   // rotate the vector onto the positive x axis
   always_comb begin
      xs       = c_in.x >>> shift;
      ys       = c_in.y >>> shift;
      av       = $signed({{(saz_pkg::CW-32){1'b0}}, atan});
      c_in_nxt = c_in;
      if (!c_in.y[saz_pkg::CW-1]) begin
         c_in_nxt.x = c_in.x + ys;
         c_in_nxt.y = c_in.y - xs;
         c_in_nxt.z = c_in.z + av;
      end else begin
         c_in_nxt.x = c_in.x - ys;
         c_in_nxt.y = c_in.y + xs;
         c_in_nxt.z = c_in.z - av;
      end
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in_nxt;
   end

   assign c_out = c_ff;

endmodule

// ===== rtl/saz_sincos.sv =====
// pipelined cordic sine and cosine of an angle in binary turns
module saz_sincos (
   input  logic            clock,
   input  logic [31:0]     ang,
   output saz_pkg::qv_type cos_out,
   output saz_pkg::qv_type sin_out
);

   saz_pkg::cstate_type pre_ff;
   saz_pkg::cstate_type pre_in;
   saz_pkg::cstate_type link [saz_pkg::STAGES+1];
   saz_pkg::cw_type     t;
   saz_pkg::cw_type     xo;
   saz_pkg::cw_type     yo;
   saz_pkg::qv_type     cos_ff;
   saz_pkg::qv_type     sin_ff;

   // fold the angle into the right half plane
   always_comb begin
      t        = $signed({{(saz_pkg::CW-32){ang[31]}}, ang});
      pre_in.x = saz_pkg::CORDIC_K;
      pre_in.y = '0;
      pre_in.z = t;
      pre_in.flag = 1'b0;
      if (t > saz_pkg::QTR_TURN) begin
         pre_in.z    = t - saz_pkg::HALF_TURN;
         pre_in.flag = 1'b1;
      end else if (t < saz_pkg::NQTR_TURN) begin
         pre_in.z    = t + saz_pkg::HALF_TURN;
         pre_in.flag = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

   assign link[0] = pre_ff;

   // row of rotation cells
   for (genvar i = 0; i < saz_pkg::STAGES; i++) begin : g_stage
      saz_rot_cell u_rot (
         .clock (clock),
         .shift (6'(i)),
         .atan  (saz_pkg::atan_entry(i)),
         .c_in  (link[i]),
         .c_out (link[i+1])
      );
   end

   // undo the half turn fold
   always_comb begin
      xo = link[saz_pkg::STAGES].flag ? -link[saz_pkg::STAGES].x : link[saz_pkg::STAGES].x;
      yo = link[saz_pkg::STAGES].flag ? -link[saz_pkg::STAGES].y : link[saz_pkg::STAGES].y;
   end

   always_ff @(posedge clock) begin
      cos_ff <= xo[saz_pkg::QW-1:0];
      sin_ff <= yo[saz_pkg::QW-1:0];
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ===== rtl/saz_vector.sv =====
// pipelined cordic atan2 in turns and magnitude of a q30 vector
module saz_vector (
   input  logic            clock,
   input  saz_pkg::qv_type x_in,
   input  saz_pkg::qv_type y_in,
   output saz_pkg::cw_type angle,
   output saz_pkg::qv_type mag
);

   saz_pkg::cstate_type pre_ff;
   saz_pkg::cstate_type pre_in;
   saz_pkg::cstate_type link [saz_pkg::STAGES+1];
   saz_pkg::cw_type     xe;
   saz_pkg::cw_type     ye;
   logic signed [2*saz_pkg::CW-1:0] mprod;
   saz_pkg::cw_type     angle_ff;
   saz_pkg::qv_type     mag_ff;

   // flip left half plane vectors and flag the zero vector
   always_comb begin
      xe          = $signed({{(saz_pkg::CW-saz_pkg::QW){x_in[saz_pkg::QW-1]}}, x_in});
      ye          = $signed({{(saz_pkg::CW-saz_pkg::QW){y_in[saz_pkg::QW-1]}}, y_in});
      pre_in.x    = xe;
      pre_in.y    = ye;
      pre_in.z    = '0;
      pre_in.flag = (x_in == '0) && (y_in == '0);
      if (xe[saz_pkg::CW-1]) begin
         pre_in.x = -xe;
         pre_in.y = -ye;
         pre_in.z = saz_pkg::HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      pre_ff <= pre_in;
   end

   assign link[0] = pre_ff;

   // row of vectoring cells
   for (genvar i = 0; i < saz_pkg::STAGES; i++) begin : g_stage
      saz_vec_cell u_vec (
         .clock (clock),
         .shift (6'(i)),
         .atan  (saz_pkg::atan_entry(i)),
         .c_in  (link[i]),
         .c_out (link[i+1])
      );
   end

   // gain correction of the magnitude
   assign mprod = link[saz_pkg::STAGES].x * saz_pkg::CORDIC_K + (72'sd1 <<< 29);

   always_ff @(posedge clock) begin
      if (link[saz_pkg::STAGES].flag) begin
         angle_ff <= '0;
         mag_ff   <= '0;
      end else begin
         angle_ff <= link[saz_pkg::STAGES].z;
         mag_ff   <= mprod[saz_pkg::QW+29:30];
      end
   end

   assign angle = angle_ff;
   assign mag   = mag_ff;

endmodule

// ===== rtl/solar_azimuth_zenith_core.sv =====
// solar azimuth and zenith from a day offset, fully pipelined cordic datapath
// throughput: one transfer per cycle, busy is never raised; seven cordic rows in
//   series set the latency, every row takes a new item each cycle
// reset: clears the result strobe pipeline and loads the default site registers;
//   the site angle pipeline settles from the site registers well ahead of any item
module solar_azimuth_zenith_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [32:0] req_day_offset,
   output logic               rsp_strobe,
   output logic signed [30:0] rsp_sun_azimuth,
   output logic        [29:0] rsp_sun_zenith,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic        [2:0]  paddr,
   input  logic        [31:0] pwdata,
   output logic        [31:0] prdata,
   output logic               pready
);

   localparam int S = saz_pkg::SC_LAT;

   typedef struct packed {
      logic [31:0] l;
      logic [31:0] e;
      logic [31:0] g;
   } ph1_type;

   // csr registers
   logic [27:0] lat_ff;
   logic [28:0] lon_ff;
   logic        csr_wr;

   assign csr_wr = psel & penable & pwrite;
   assign pready = 1'b1;
   assign busy   = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= 28'd33872465;
         lon_ff <= 29'd95288505;
      end else if (csr_wr) begin
         if (paddr[2] == saz_pkg::REG_LAT) begin
            lat_ff <= pwdata[27:0];
         end else begin
            lon_ff <= pwdata[28:0];
         end
      end
   end

   assign prdata = (paddr[2] == saz_pkg::REG_LON) ? {3'b0, lon_ff} : {4'b0, lat_ff};

   // site angles to turns: round(d * 512 / 45) via reciprocal and one correction
   logic signed [28:0] sd [2];
   logic        s1_ff [2];
   logic [37:0] p1_ff [2];
   logic        s2_ff [2];
   logic [37:0] p2_ff [2];
   logic [57:0] ml_ff [2];
   logic [56:0] mh_ff [2];
   logic        s3_ff [2];
   logic [37:0] p3_ff [2];
   logic [33:0] q3_ff [2];
   logic [31:0] st_ff [2];
   logic [77:0] msum [2];
   logic [39:0] rem  [2];
   logic [33:0] qc   [2];
   logic [28:0] mag_d [2];

   assign sd[0] = $signed({lat_ff[27], lat_ff});
   assign sd[1] = $signed(lon_ff);

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         mag_d[k] = sd[k][28] ? 29'(-sd[k]) : 29'(sd[k]);
         msum[k]  = {20'd0, ml_ff[k]} + ({21'd0, mh_ff[k]} << 20);
         rem[k]   = {2'b0, p3_ff[k]} - 40'(q3_ff[k] * 6'd45);
         qc[k]    = (rem[k] >= 40'd45) ? q3_ff[k] + 34'd1 : q3_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 2; k++) begin
         s1_ff[k] <= sd[k][28];
         p1_ff[k] <= {mag_d[k], 9'd0} + 38'd22;
         s2_ff[k] <= s1_ff[k];
         p2_ff[k] <= p1_ff[k];
         ml_ff[k] <= p1_ff[k] * saz_pkg::MREC[19:0];
         mh_ff[k] <= p1_ff[k] * saz_pkg::MREC[38:20];
         s3_ff[k] <= s2_ff[k];
         p3_ff[k] <= p2_ff[k];
         q3_ff[k] <= msum[k][77:44];
         st_ff[k] <= s3_ff[k] ? 32'(-qc[k]) : qc[k][31:0];
      end
   end

   // sine and cosine of latitude, recomputed every cycle
   saz_pkg::qv_type cp;
   saz_pkg::qv_type sp;

   saz_sincos u_lat (
      .clock   (clock),
      .ang     (st_ff[0]),
      .cos_out (cp),
      .sin_out (sp)
   );

   // transfer strobe pipeline
   logic vld_ff [saz_pkg::LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < saz_pkg::LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= start;
         for (int k = 1; k < saz_pkg::LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   assign rsp_strobe = vld_ff[saz_pkg::LAT-1];

   // time terms: split products, then recombine
   logic signed [32:0] n_ff;
   saz_pkg::pp_type    ppl_ff;
   saz_pkg::pp_type    ppg_ff;
   saz_pkg::pp_type    ppe_ff;
   saz_pkg::pp_type    ppm_ff;
   logic [31:0]        lt_ff;
   logic [31:0]        gt_ff;
   logic [31:0]        et_ff;
   logic [31:0]        mt_ff;
   logic [63:0]        esum;

   assign esum = 64'd0 - saz_pkg::hsum(ppe_ff);

   always_ff @(posedge clock) begin
      n_ff   <= req_day_offset;
      ppl_ff <= saz_pkg::pprod(n_ff, saz_pkg::RATE_L);
      ppg_ff <= saz_pkg::pprod(n_ff, saz_pkg::RATE_G);
      ppe_ff <= saz_pkg::pprod(n_ff, saz_pkg::RATE_EPS);
      ppm_ff <= saz_pkg::pprod(n_ff, saz_pkg::RATE_GMST);
      lt_ff  <= saz_pkg::L0_T + 32'(saz_pkg::hsum(ppl_ff) >> 32);
      gt_ff  <= saz_pkg::G0_T + 32'(saz_pkg::hsum(ppg_ff) >> 32);
      et_ff  <= saz_pkg::EPS0_T + esum[63:32];
      mt_ff  <= saz_pkg::GMST0_T + 32'(saz_pkg::hsum(ppm_ff) >> 32);
   end

   // sin and cos of mean anomaly and its double
   saz_pkg::qv_type c1;
   saz_pkg::qv_type s1;
   saz_pkg::qv_type c2;
   saz_pkg::qv_type s2;

   saz_sincos u_g1 (.clock(clock), .ang(gt_ff), .cos_out(c1), .sin_out(s1));
   saz_sincos u_g2 (.clock(clock), .ang({gt_ff[30:0], 1'b0}), .cos_out(c2), .sin_out(s2));

   ph1_type ph1_ff [S];

   always_ff @(posedge clock) begin
      ph1_ff[0] <= '{l: lt_ff, e: et_ff, g: mt_ff};
      for (int k = 1; k < S; k++) begin
         ph1_ff[k] <= ph1_ff[k-1];
      end
   end

   // equation of center, then ecliptic longitude
   saz_pkg::qv_type e1_ff;
   saz_pkg::qv_type e2_ff;
   logic [31:0]     l2_ff;
   logic [31:0]     eps2_ff;
   logic [31:0]     gm2_ff;
   logic [31:0]     lam_ff;
   logic [31:0]     eps3_ff;
   logic [31:0]     gm3_ff;
   saz_pkg::qv_type ec_sum;

   assign ec_sum = e1_ff + e2_ff;

   always_ff @(posedge clock) begin
      e1_ff   <= saz_pkg::mulq($signed({1'b0, saz_pkg::EC1_T}), s1);
      e2_ff   <= saz_pkg::mulq($signed({1'b0, saz_pkg::EC2_T}), s2);
      l2_ff   <= ph1_ff[S-1].l;
      eps2_ff <= ph1_ff[S-1].e;
      gm2_ff  <= ph1_ff[S-1].g;
      lam_ff  <= l2_ff + ec_sum[31:0];
      eps3_ff <= eps2_ff;
      gm3_ff  <= gm2_ff;
   end

   // sin and cos of ecliptic longitude and obliquity
   saz_pkg::qv_type cl;
   saz_pkg::qv_type sl;
   saz_pkg::qv_type ce;
   saz_pkg::qv_type se;

   saz_sincos u_lam (.clock(clock), .ang(lam_ff), .cos_out(cl), .sin_out(sl));
   saz_sincos u_eps (.clock(clock), .ang(eps3_ff), .cos_out(ce), .sin_out(se));

   // equatorial vector
   saz_pkg::qv_type xq_ff;
   saz_pkg::qv_type yq_ff;
   saz_pkg::qv_type zq_ff;

   always_ff @(posedge clock) begin
      xq_ff <= cl;
      yq_ff <= saz_pkg::mulq(ce, sl);
      zq_ff <= saz_pkg::mulq(se, sl);
   end

   // sidereal time and declination height wait for right ascension
   logic [31:0]     gmd_ff [2*S+1];
   saz_pkg::qv_type zd_ff  [S];

   always_ff @(posedge clock) begin
      gmd_ff[0] <= gm3_ff;
      for (int k = 1; k < 2*S+1; k++) begin
         gmd_ff[k] <= gmd_ff[k-1];
      end
      zd_ff[0] <= zq_ff;
      for (int k = 1; k < S; k++) begin
         zd_ff[k] <= zd_ff[k-1];
      end
   end

   // right ascension and declination
   saz_pkg::cw_type ra;
   saz_pkg::qv_type m1;
   saz_pkg::cw_type dec;
   saz_pkg::qv_type m2;

   saz_vector u_ra  (.clock(clock), .x_in(xq_ff), .y_in(yq_ff), .angle(ra), .mag(m1));
   saz_vector u_dec (.clock(clock), .x_in(m1), .y_in(zd_ff[S-1]), .angle(dec), .mag(m2));

   // hour angle waits for declination
   logic [31:0] ha_in;
   logic [31:0] had_ff [S];

   assign ha_in = gmd_ff[2*S] - st_ff[1] - ra[31:0];

   always_ff @(posedge clock) begin
      had_ff[0] <= ha_in;
      for (int k = 1; k < S; k++) begin
         had_ff[k] <= had_ff[k-1];
      end
   end

   saz_pkg::qv_type ch;
   saz_pkg::qv_type sh;
   saz_pkg::qv_type cd;
   saz_pkg::qv_type sdc;

   saz_sincos u_ha (.clock(clock), .ang(had_ff[S-1]), .cos_out(ch), .sin_out(sh));
   saz_sincos u_dc (.clock(clock), .ang(dec[31:0]), .cos_out(cd), .sin_out(sdc));

   // rotation into the horizon frame
   saz_pkg::qv_type cdch_ff;
   saz_pkg::qv_type a1_ff;
   saz_pkg::qv_type yh1_ff;
   saz_pkg::qv_type c1_ff;
   saz_pkg::qv_type xh_ff;
   saz_pkg::qv_type yh_ff;
   saz_pkg::qv_type zh_ff;
   saz_pkg::qv_type zhd_ff [S];
   saz_pkg::qv_type cp1_ff;
   saz_pkg::qv_type sp1_ff;

   always_ff @(posedge clock) begin
      cdch_ff <= saz_pkg::mulq(cd, ch);
      a1_ff   <= saz_pkg::mulq(cp, sdc);
      yh1_ff  <= saz_pkg::mulq(cd, sh);
      c1_ff   <= saz_pkg::mulq(sp, sdc);
      cp1_ff  <= cp;
      sp1_ff  <= sp;
      xh_ff   <= a1_ff - saz_pkg::mulq(sp1_ff, cdch_ff);
      zh_ff   <= c1_ff + saz_pkg::mulq(cp1_ff, cdch_ff);
      yh_ff   <= yh1_ff;
      zhd_ff[0] <= zh_ff;
      for (int k = 1; k < S; k++) begin
         zhd_ff[k] <= zhd_ff[k-1];
      end
   end

   // azimuth and ground distance, then zenith
   saz_pkg::cw_type az;
   saz_pkg::qv_type r;
   saz_pkg::cw_type zen;
   saz_pkg::qv_type m3;
   logic [31:0]     azd_ff [S];

   saz_vector u_az  (.clock(clock), .x_in(xh_ff), .y_in(yh_ff), .angle(az), .mag(r));
   saz_vector u_zen (.clock(clock), .x_in(zhd_ff[S-1]), .y_in(r), .angle(zen), .mag(m3));

   always_ff @(posedge clock) begin
      azd_ff[0] <= az[31:0];
      for (int k = 1; k < S; k++) begin
         azd_ff[k] <= azd_ff[k-1];
      end
   end

   // turns to radians and result registers
   logic signed [32:0] az_neg;
   logic signed [32:0] zc;
   logic signed [65:0] pa;
   logic signed [65:0] pz;
   logic        [30:0] az_in;
   logic        [29:0] zen_in;
   logic        [30:0] az_ff;
   logic        [29:0] zen_ff;

   always_comb begin
      az_neg = -$signed({azd_ff[S-1][31], azd_ff[S-1]});
      if (zen[saz_pkg::CW-1]) begin
         zc = '0;
      end else if (zen > saz_pkg::HALF_TURN) begin
         zc = saz_pkg::HALF_TURN[32:0];
      end else begin
         zc = zen[32:0];
      end
      pa     = az_neg * $signed({1'b0, saz_pkg::PI_Q30}) + (66'sd1 <<< 32);
      pz     = zc * $signed({1'b0, saz_pkg::PI_Q30}) + (66'sd1 <<< 32);
      az_in  = pa[63:33];
      zen_in = pz[62:33];
   end

   always_ff @(posedge clock) begin
      az_ff  <= az_in;
      zen_ff <= zen_in;
   end

   assign rsp_sun_azimuth = $signed(az_ff);
   assign rsp_sun_zenith  = zen_ff;

endmodule
